// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and sideband types for the neutrino pz solver.
// No dependencies.
package nps_pkg;

  localparam int IN_W   = 17;  // signed momentum inputs
  localparam int E_W    = 16;  // lepton energy
  localparam int WM_W   = 12;  // W mass register
  localparam int IN_TDATA_W = 104;

  localparam logic [WM_W-1:0] WM_RESET = 12'd1286;

  localparam int P_W    = 34;  // 17x17 products
  localparam int WW_W   = 24;  // mW^2
  localparam int MET2_W = 34;
  localparam int M_W    = 37;  // M = mW^2 + 2 met.lep_T, signed
  localparam int MMAG_W = 36;
  localparam int DEN_W  = 35;  // E^2 - pz^2, signed
  localparam int ADEN_W = 34;
  localparam int BASE_W = 54;  // s*M*pz, signed
  localparam int MSQ_W  = 72;
  localparam int PROD_W = 68;
  localparam int Q_W    = 72;  // discriminant radicand
  localparam int ROOT_W = Q_W / 2 + 1;
  localparam int RE_W   = 53;  // root * E
  localparam int N_W    = 56;  // signed numerators
  localparam int NUM_W  = 57;  // 2|n| + 2|D|
  localparam int D2_W   = 36;  // 4|D|

  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic [ADEN_W-1:0]        aden;
    logic [E_W-1:0]           e;
    logic [MET2_W-1:0]        met2;
    logic                     cplx;
    logic                     zero;
  } sq_side_t;

  typedef struct packed {
    logic [MET2_W-1:0] met2;
    logic              cplx;
    logic              zero;
  } dv_side_t;

endpackage

// ===== rtl/neutrino_pz_w_mass_solver_unit.sv =====
`timescale 1ns / 1ps
// Neutrino pz from the W mass constraint: pipelined, one item per cycle.
// Most of the pipeline depth lies in the bit-serial discriminant root, the pz
// divider and the energy roots.
// Throughput one item per cycle; the whole pipe holds while the output stalls.
// Reset clears all valid bits and loads w_mass with 1286 (80.375 GeV).
// Depends on nps_pkg, nps_isqrt and nps_rdiv.
module neutrino_pz_w_mass_solver_unit #(
  parameter int MOMENTUM_BITS = 17
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          w_mass_we_i,
  input  logic [nps_pkg::WM_W-1:0]                      w_mass_i,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // lep_px, lep_py, lep_pz, lep_energy, met_px, met_py, zero pad
  input  logic [nps_pkg::IN_TDATA_W-1:0]                s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // first_pz, second_pz, first_energy, second_energy, zero pad
  output logic [((4*MOMENTUM_BITS+7)/8)*8-1:0]          m_axis_tdata,
  // complex_flag, zero_denominator, saturated
  output logic [2:0]                                    m_axis_tuser
);
  localparam int MB    = MOMENTUM_BITS;
  localparam int OUT_W = ((4 * MB + 7) / 8) * 8;
  localparam int ER_W  = (2 * MB > 36) ? 2 * MB : 36;
  localparam int EH_W  = ER_W / 2;
  localparam int IW    = nps_pkg::IN_W;
  localparam int EW    = nps_pkg::E_W;
  localparam int SQ_SB = $bits(nps_pkg::sq_side_t);
  localparam int DV_SB = $bits(nps_pkg::dv_side_t);
  localparam int E_SB  = 2 * MB + 3;

  logic en;
  logic [nps_pkg::WM_W-1:0] wm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm_q <= nps_pkg::WM_RESET;
    end else if (w_mass_we_i) begin
      wm_q <= w_mass_i;
    end
  end

  logic out_valid_q;
  assign en            = m_axis_tready || !out_valid_q;
  assign s_axis_tready = en;

  logic signed [IW-1:0] lx, ly, lz, mx, my;
  logic [EW-1:0]        le;
  assign lx = s_axis_tdata[IW-1:0];
  assign ly = s_axis_tdata[2*IW-1:IW];
  assign lz = s_axis_tdata[3*IW-1:2*IW];
  assign le = s_axis_tdata[3*IW+EW-1:3*IW];
  assign mx = s_axis_tdata[4*IW+EW-1:3*IW+EW];
  assign my = s_axis_tdata[5*IW+EW-1:4*IW+EW];

  // stage 1: products
  logic v1_q;
  logic signed [nps_pkg::P_W-1:0] pxx_q, pyy_q, mxx_q, myy_q, zz_q;
  logic [2*EW-1:0]                ee_q;
  logic [nps_pkg::WW_W-1:0]       ww_q;
  logic signed [IW-1:0]           lz1_q;
  logic [EW-1:0]                  e1_q;

  // stage 2: M, D, met^2
  logic v2_q;
  logic [nps_pkg::MET2_W-1:0]     met2_2_q;
  logic signed [nps_pkg::M_W-1:0] m2_q;
  logic signed [nps_pkg::DEN_W-1:0] den2_q;
  logic signed [IW-1:0]           lz2_q;
  logic [EW-1:0]                  e2_q;

  // stage 3: signs and magnitudes
  logic v3_q;
  logic                           neg3_q, zero3_q;
  logic [nps_pkg::ADEN_W-1:0]     aden3_q;
  logic signed [nps_pkg::M_W-1:0] sm3_q;
  logic [nps_pkg::MMAG_W-1:0]     mmag3_q;
  logic [nps_pkg::MET2_W-1:0]     met2_3_q;
  logic signed [IW-1:0]           lz3_q;
  logic [EW-1:0]                  e3_q;

  // stage 4: wide products
  logic v4_q;
  logic signed [nps_pkg::BASE_W-1:0] base4_q;
  logic [nps_pkg::MSQ_W-1:0]      msq4_q;
  logic [nps_pkg::PROD_W-1:0]     prod4_q;
  logic                           neg4_q, zero4_q;
  logic [nps_pkg::ADEN_W-1:0]     aden4_q;
  logic [nps_pkg::MET2_W-1:0]     met2_4_q;
  logic [EW-1:0]                  e4_q;

  // stage 5: discriminant
  logic v5_q;
  logic [nps_pkg::Q_W-1:0]        q5_q;
  nps_pkg::sq_side_t              side5_q;

  logic [nps_pkg::Q_W-1:0]        prod_x4;
  logic                           cplx_d;
  assign prod_x4 = nps_pkg::Q_W'(prod4_q) << 2;
  assign cplx_d  = !neg4_q && !zero4_q && (prod_x4 > nps_pkg::Q_W'(msq4_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= mx * lx;
      pyy_q <= my * ly;
      mxx_q <= mx * mx;
      myy_q <= my * my;
      zz_q  <= lz * lz;
      ee_q  <= le * le;
      ww_q  <= wm_q * wm_q;
      lz1_q <= lz;
      e1_q  <= le;

      met2_2_q <= nps_pkg::MET2_W'($unsigned(mxx_q)) + nps_pkg::MET2_W'($unsigned(myy_q));
      m2_q     <= $signed(nps_pkg::M_W'(ww_q)) +
                  ((nps_pkg::M_W'(pxx_q) + nps_pkg::M_W'(pyy_q)) <<< 1);
      den2_q   <= $signed(nps_pkg::DEN_W'(ee_q)) - nps_pkg::DEN_W'(zz_q);
      lz2_q    <= lz1_q;
      e2_q     <= e1_q;

      neg3_q   <= den2_q[nps_pkg::DEN_W-1];
      zero3_q  <= (den2_q == '0);
      aden3_q  <= nps_pkg::ADEN_W'($unsigned(den2_q[nps_pkg::DEN_W-1] ? -den2_q : den2_q));
      sm3_q    <= den2_q[nps_pkg::DEN_W-1] ? -m2_q : m2_q;
      mmag3_q  <= nps_pkg::MMAG_W'($unsigned(m2_q[nps_pkg::M_W-1] ? -m2_q : m2_q));
      met2_3_q <= met2_2_q;
      lz3_q    <= lz2_q;
      e3_q     <= e2_q;

      base4_q  <= sm3_q * lz3_q;
      msq4_q   <= nps_pkg::MSQ_W'(mmag3_q) * nps_pkg::MSQ_W'(mmag3_q);
      prod4_q  <= nps_pkg::PROD_W'(met2_3_q) * nps_pkg::PROD_W'(aden3_q);
      neg4_q   <= neg3_q;
      zero4_q  <= zero3_q;
      aden4_q  <= aden3_q;
      met2_4_q <= met2_3_q;
      e4_q     <= e3_q;

      // D < 0 adds the term, D > 0 subtracts it; a complex case is cleared to zero
      if (neg4_q) begin
        q5_q <= nps_pkg::Q_W'(msq4_q) + prod_x4;
      end else if (cplx_d) begin
        q5_q <= '0;
      end else begin
        q5_q <= nps_pkg::Q_W'(msq4_q) - prod_x4;
      end
      side5_q.base <= base4_q;
      side5_q.aden <= aden4_q;
      side5_q.e    <= e4_q;
      side5_q.met2 <= met2_4_q;
      side5_q.cplx <= cplx_d;
      side5_q.zero <= zero4_q;
    end
  end

  // discriminant root
  logic                               sq_v;
  logic [0:0][nps_pkg::ROOT_W-1:0]    sq_root;
  logic [SQ_SB-1:0]                   sq_sb;
  nps_pkg::sq_side_t                  sq_side;

  nps_isqrt #(
    .RW    (nps_pkg::Q_W),
    .LANES (1),
    .SBW   (SQ_SB)
  ) u_disc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rad_i   (q5_q),
    .sb_i    (side5_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );
  assign sq_side = nps_pkg::sq_side_t'(sq_sb);

  // R1: root * E, R2: numerators, R3: divider operands
  logic r1_v_q, r2_v_q, r3_v_q;
  logic [nps_pkg::RE_W-1:0]           re1_q;
  nps_pkg::sq_side_t                  side_r1_q;
  logic signed [nps_pkg::N_W-1:0]     n1_q, n2_q;
  logic [nps_pkg::ADEN_W-1:0]         aden_r2_q;
  nps_pkg::dv_side_t                  side_r2_q, side_r3_q;
  logic [1:0][nps_pkg::NUM_W-1:0]     num3_q;
  logic [1:0]                         nneg3_q;
  logic [nps_pkg::D2_W-1:0]           d2_3_q;

  logic signed [nps_pkg::N_W-1:0]     base_ext, re_ext;
  logic signed [nps_pkg::N_W-1:0]     mag1, mag2;
  assign base_ext = nps_pkg::N_W'(side_r1_q.base);
  assign re_ext   = side_r1_q.cplx ? '0 : $signed(nps_pkg::N_W'(re1_q));
  assign mag1     = n1_q[nps_pkg::N_W-1] ? -n1_q : n1_q;
  assign mag2     = n2_q[nps_pkg::N_W-1] ? -n2_q : n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
    end else if (en) begin
      r1_v_q <= sq_v;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re1_q     <= nps_pkg::RE_W'(sq_root[0]) * nps_pkg::RE_W'(sq_side.e);
      side_r1_q <= sq_side;

      n1_q           <= base_ext + re_ext;
      n2_q           <= base_ext - re_ext;
      aden_r2_q      <= side_r1_q.aden;
      side_r2_q.met2 <= side_r1_q.met2;
      side_r2_q.cplx <= side_r1_q.cplx;
      side_r2_q.zero <= side_r1_q.zero;

      num3_q[0] <= (nps_pkg::NUM_W'($unsigned(mag1)) << 1) +
                   (nps_pkg::NUM_W'(aden_r2_q) << 1);
      num3_q[1] <= (nps_pkg::NUM_W'($unsigned(mag2)) << 1) +
                   (nps_pkg::NUM_W'(aden_r2_q) << 1);
      nneg3_q   <= {n2_q[nps_pkg::N_W-1], n1_q[nps_pkg::N_W-1]};
      d2_3_q    <= nps_pkg::D2_W'(aden_r2_q) << 2;
      side_r3_q <= side_r2_q;
    end
  end

  logic              dv_v;
  logic [1:0][MB-1:0] dv_pz;
  logic              dv_sat;
  logic [DV_SB-1:0]  dv_sb;
  nps_pkg::dv_side_t dv_side;

  nps_rdiv #(
    .MB  (MB),
    .SBW (DV_SB)
  ) u_pz_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r3_v_q),
    .num_i   (num3_q),
    .neg_i   (nneg3_q),
    .den_i   (d2_3_q),
    .sb_i    (side_r3_q),
    .valid_o (dv_v),
    .pz_o    (dv_pz),
    .sat_o   (dv_sat),
    .sb_o    (dv_sb)
  );
  assign dv_side = nps_pkg::dv_side_t'(dv_sb);

  // E1: pz^2, E2: met^2 + pz^2
  logic e1_v_q, e2_v_q;
  logic [1:0][2*MB-1:0]  sq1_q;
  logic [1:0][MB-1:0]    pz_e1_q, pz_e2_q;
  logic                  sat_e1_q, sat_e2_q;
  nps_pkg::dv_side_t     side_e1_q, side_e2_q;
  logic [1:0][ER_W-1:0]  rad_e2_q;
  logic [1:0][MB-1:0]    pzmag;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pzmag[l] = dv_pz[l][MB-1] ? -dv_pz[l] : dv_pz[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
    end else if (en) begin
      e1_v_q <= dv_v;
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        sq1_q[l]    <= (2*MB)'(pzmag[l]) * (2*MB)'(pzmag[l]);
        rad_e2_q[l] <= ER_W'(side_e1_q.met2) + ER_W'(sq1_q[l]);
      end
      pz_e1_q   <= dv_pz;
      sat_e1_q  <= dv_sat;
      side_e1_q <= dv_side;
      pz_e2_q   <= pz_e1_q;
      sat_e2_q  <= sat_e1_q;
      side_e2_q <= side_e1_q;
    end
  end

  logic                   en_v;
  logic [1:0][EH_W:0]     en_root;
  logic [E_SB-1:0]        en_sb;

  nps_isqrt #(
    .RW    (ER_W),
    .LANES (2),
    .SBW   (E_SB)
  ) u_energy_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e2_v_q),
    .rad_i   (rad_e2_q),
    .sb_i    ({pz_e2_q, sat_e2_q, side_e2_q.cplx, side_e2_q.zero}),
    .valid_o (en_v),
    .root_o  (en_root),
    .sb_o    (en_sb)
  );

  // output register
  logic [1:0][MB-1:0] o_pz_q, o_en_q, en_clip;
  logic [2:0]         o_user_q;
  logic               o_zero, o_cplx, o_sat;
  logic [1:0][MB-1:0] o_pz;

  assign o_zero = en_sb[0];
  assign o_cplx = en_sb[1];
  assign o_sat  = en_sb[2];
  assign o_pz   = en_sb[E_SB-1:3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      en_clip[l] = (en_root[l][EH_W:MB] != '0) ? {MB{1'b1}} : en_root[l][MB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= en_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (o_zero) begin
        o_pz_q   <= '0;
        o_en_q   <= '0;
        o_user_q <= 3'b010;
      end else begin
        o_pz_q   <= o_pz;
        o_en_q   <= en_clip;
        o_user_q <= {o_sat, 1'b0, o_cplx};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({o_en_q[1], o_en_q[0], o_pz_q[1], o_pz_q[0]});
  assign m_axis_tuser  = o_user_q;

endmodule

// ===== rtl/nps_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined round-to-nearest integer square root, one root bit per stage.
// Uses no package; lanes share valid and sideband.
module nps_isqrt #(
  parameter int RW    = 72,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][RW-1:0]    rad_i,
  input  logic [SBW-1:0]              sb_i,
  output logic                        valid_o,
  output logic [LANES-1:0][RW/2:0]    root_o,
  output logic [SBW-1:0]              sb_o
);
  localparam int HW = RW / 2;

  logic                       v_q   [1:HW];
  logic [LANES-1:0][RW-1:0]   rem_q [1:HW];
  logic [LANES-1:0][HW-1:0]   rt_q  [1:HW];
  logic [SBW-1:0]             sb_q  [1:HW];

  logic                       vo_q;
  logic [LANES-1:0][HW:0]     root_q;
  logic [SBW-1:0]             sbo_q;

  for (genvar s = 0; s < HW; s++) begin : g_stage
    localparam int B = HW - 1 - s;
    logic                     v_in;
    logic [LANES-1:0][RW-1:0] r_in, r_d;
    logic [LANES-1:0][HW-1:0] t_in, t_d;
    logic [SBW-1:0]           sb_in;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = rad_i;
      assign t_in  = '0;
      assign sb_in = sb_i;
    end else begin : g_next
      assign v_in  = v_q[s];
      assign r_in  = rem_q[s];
      assign t_in  = rt_q[s];
      assign sb_in = sb_q[s];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    always_comb begin
      logic [RW:0] trial;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        trial = ((RW+1)'(t_in[l]) << (B + 1)) | ((RW+1)'(1) << (2 * B));
        if ((RW+1)'(r_in[l]) >= trial) begin
          r_d[l] = r_in[l] - trial[RW-1:0];
          t_d[l] = t_in[l] | (HW'(1) << B);
        end else begin
          r_d[l] = r_in[l];
          t_d[l] = t_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r_d;
        rt_q[s+1]  <= t_d;
        sb_q[s+1]  <= sb_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[HW];
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        root_q[l] <= (HW+1)'(rt_q[HW][l]) +
                     (HW+1)'(rem_q[HW][l] > RW'(rt_q[HW][l]));
      end
      sbo_q <= sb_q[HW];
    end
  end

  assign valid_o = vo_q;
  assign root_o  = root_q;
  assign sb_o    = sbo_q;

endmodule

// ===== rtl/nps_rdiv.sv =====
`timescale 1ns / 1ps
// Pipelined rounding divider for the two pz numerators, restoring, one
// quotient bit per stage, with sign and saturation. Depends on nps_pkg.
module nps_rdiv #(
  parameter int MB  = 17,
  parameter int SBW = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [1:0][nps_pkg::NUM_W-1:0]       num_i,  // 2|n| + d
  input  logic [1:0]                           neg_i,
  input  logic [nps_pkg::D2_W-1:0]             den_i,  // 2d
  input  logic [SBW-1:0]                       sb_i,
  output logic                                 valid_o,
  output logic [1:0][MB-1:0]                   pz_o,
  output logic                                 sat_o,
  output logic [SBW-1:0]                       sb_o
);
  localparam int NW = nps_pkg::NUM_W;
  localparam int DW = nps_pkg::D2_W;
  localparam int CW = ((NW > DW + MB) ? NW : DW + MB) + 1;

  logic                 v_q   [0:MB];
  logic [1:0][NW-1:0]   rem_q [0:MB];
  logic [1:0][MB-1:0]   quo_q [0:MB];
  logic [DW-1:0]        den_q [0:MB];
  logic [1:0]           neg_q [0:MB];
  logic [1:0]           ovf_q [0:MB];
  logic [SBW-1:0]       sb_q  [0:MB];

  logic                 vo_q;
  logic [1:0][MB-1:0]   pz_q;
  logic                 sat_q;
  logic [SBW-1:0]       sbo_q;

  logic [1:0]           ovf_d;
  logic [1:0][MB-1:0]   pz_d;
  logic [1:0]           sat_l;

  // quotient too wide for MB bits
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf_d[l] = CW'(num_i[l]) >= (CW'(den_i) << MB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf_d;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar j = 0; j < MB; j++) begin : g_stage
    localparam int K = MB - 1 - j;
    logic [1:0][NW-1:0] r_d;
    logic [1:0][MB-1:0] q_d;

    always_comb begin
      logic [CW-1:0] sh;
      sh = CW'(den_q[j]) << K;
      for (int l = 0; l < 2; l++) begin
        if (CW'(rem_q[j][l]) >= sh) begin
          r_d[l] = rem_q[j][l] - sh[NW-1:0];
          q_d[l] = quo_q[j][l] | (MB'(1) << K);
        end else begin
          r_d[l] = rem_q[j][l];
          q_d[l] = quo_q[j][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= r_d;
        quo_q[j+1] <= q_d;
        den_q[j+1] <= den_q[j];
        neg_q[j+1] <= neg_q[j];
        ovf_q[j+1] <= ovf_q[j];
        sb_q[j+1]  <= sb_q[j];
      end
    end
  end

  // positive limit 2^(MB-1)-1, negative limit 2^(MB-1)
  always_comb begin
    logic big;
    big = 1'b0;
    for (int l = 0; l < 2; l++) begin
      big = quo_q[MB][l][MB-1] &&
            (!neg_q[MB][l] || (quo_q[MB][l][MB-2:0] != '0));
      sat_l[l] = ovf_q[MB][l] || big;
      if (sat_l[l]) begin
        pz_d[l] = neg_q[MB][l] ? {1'b1, {(MB-1){1'b0}}} : {1'b0, {(MB-1){1'b1}}};
      end else begin
        pz_d[l] = neg_q[MB][l] ? -quo_q[MB][l] : quo_q[MB][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[MB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pz_q  <= pz_d;
      sat_q <= |sat_l;
      sbo_q <= sb_q[MB];
    end
  end

  assign valid_o = vo_q;
  assign pz_o    = pz_q;
  assign sat_o   = sat_q;
  assign sb_o    = sbo_q;

endmodule
